[rtl/lmts_pkg.sv]
// ----------------------------------------------------------------------------
// lmts_pkg: shared types and constants of the LCD mode timing sequencer
// Request layout, phase codes, timing constants and the sprite penalty table.
// ----------------------------------------------------------------------------
package lmts_pkg;

  typedef logic [16:0] cyc_t;
  typedef logic [23:0] in_data_t;
  typedef logic [23:0] out_data_t;
  typedef logic [1:0]  op_t;

  // request kinds carried on tuser
  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_CTRL    = 2'd1;
  localparam op_t OP_STAT    = 2'd2;
  localparam op_t OP_COMPARE = 2'd3;

  // timing phases
  localparam logic [2:0] PH_OAM    = 3'd0;
  localparam logic [2:0] PH_XFER   = 3'd1;
  localparam logic [2:0] PH_HBLANK = 3'd2;
  localparam logic [2:0] PH_HINC   = 3'd3;
  localparam logic [2:0] PH_VBLANK = 3'd4;
  localparam logic [2:0] PH_VINC   = 3'd5;
  localparam logic [2:0] PH_WRAP   = 3'd6;
  localparam logic [2:0] PH_FRAME  = 3'd7;

  localparam cyc_t OFF_FRAME_LEN = 17'd70224;
  localparam cyc_t VLINE_LEN     = 17'd452;
  localparam cyc_t XFER_BASE_LEN = 17'd172;
  localparam cyc_t HLINE_LEN     = 17'd372;
  localparam cyc_t OAM_LEN       = 17'd80;
  localparam cyc_t INC_LEN       = 17'd4;

  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // result of a line compare check
  typedef struct packed {
    logic match;
    logic irq;
    logic latched;
  } chk_t;

  // transfer penalty per sprite count, saturating above ten sprites
  function automatic logic [6:0] sprite_penalty(input logic [3:0] sc);
    logic [6:0] p;
    case (sc)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd8;
      4'd2:    p = 7'd20;
      4'd3:    p = 7'd32;
      4'd4:    p = 7'd44;
      4'd5:    p = 7'd52;
      4'd6:    p = 7'd64;
      4'd7:    p = 7'd76;
      4'd8:    p = 7'd88;
      4'd9:    p = 7'd96;
      default: p = 7'd108;
    endcase
    return p;
  endfunction

endpackage

[rtl/lcd_mode_timing_sequencer.sv]
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer: scanline mode timing of an LCD controller
// Flow: a register write passes through S_DONE into the result register; a
// tick passes through S_LOOP, which walks the N phase events that the tick
// crosses, one event per cycle through the shared compare/subtract, then S_DONE.
// Requests: one at a time; in_tready is high only while idle, so a new request
// is taken only once the last result is registered; a stalled result holds the sequencer.
// Reset: synchronous, active low; display off, line 0, OAM phase, no result.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // in_tdata, from bit 0: clock_delta[5:0], write_value[7:0],
  // sprite_count[3:0], scroll_x_fine[2:0], zero fill
  input  lmts_pkg::in_data_t in_tdata,
  // in_tuser: op[1:0]
  input  lmts_pkg::op_t      in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // out_tdata, from bit 0: lcd_mode[1:0], current_line[7:0], line_match,
  // status_enables[3:0], lcdc_irq, vblank_irq, frame_done, video_mem_open,
  // sprite_mem_open, zero fill
  output lmts_pkg::out_data_t out_tdata
);
  import lmts_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  // timing state
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] line_r, line_nxt;
  cyc_t       cycle_r, cycle_nxt;
  cyc_t       plen_r, plen_nxt;
  logic [2:0] scroll_pen_r, scroll_pen_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       match_r, match_nxt;
  logic [3:0] enables_r, enables_nxt;
  logic       latched_r, latched_nxt;
  logic       disp_on_r, disp_on_nxt;
  logic [7:0] compare_r, compare_nxt;

  // per-request pulses and held request fields
  logic       lirq_r, lirq_nxt;
  logic       virq_r, virq_nxt;
  logic       done_r, done_nxt;
  logic [3:0] sc_r, sc_nxt;
  logic [2:0] sx_r, sx_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  out_data_t  out_data_r, out_data_nxt;

  // request fields
  logic [5:0] in_delta;
  logic [7:0] in_value;
  logic [3:0] in_sc;
  logic [2:0] in_sx;

  // shared compare/subtract unit
  logic       boundary;
  cyc_t       cycle_rem;
  logic [17:0] cycle_sum;

  chk_t chk;

  assign in_delta = in_tdata[5:0];
  assign in_value = in_tdata[13:6];
  assign in_sc    = in_tdata[17:14];
  assign in_sx    = in_tdata[20:18];

  assign boundary  = (cycle_r >= plen_r);
  assign cycle_rem = cycle_r - plen_r;
  assign cycle_sum = {1'b0, cycle_r} + {12'd0, in_delta};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // line compare: set match, fire once per line when enabled
  function automatic chk_t line_check(input logic [7:0] cmp, input logic [7:0] line,
                                      input logic en, input logic latched);
    chk_t c;
    c.match   = (cmp == line);
    c.irq     = c.match && en && !latched;
    c.latched = latched || c.irq;
    return c;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    line_nxt       = line_r;
    cycle_nxt      = cycle_r;
    plen_nxt       = plen_r;
    scroll_pen_nxt = scroll_pen_r;
    mode_nxt       = mode_r;
    match_nxt      = match_r;
    enables_nxt    = enables_r;
    latched_nxt    = latched_r;
    disp_on_nxt    = disp_on_r;
    compare_nxt    = compare_r;
    lirq_nxt       = lirq_r;
    virq_nxt       = virq_r;
    done_nxt       = done_r;
    sc_nxt         = sc_r;
    sx_nxt         = sx_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    chk            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lirq_nxt = 1'b0;
          virq_nxt = 1'b0;
          done_nxt = 1'b0;
          sc_nxt   = in_sc;
          sx_nxt   = in_sx;
          state_nxt = S_DONE;
          case (in_tuser)
            OP_TICK: begin
              // advance the clock counter, then walk phase boundaries
              cycle_nxt = cycle_sum[16:0];
              state_nxt = S_LOOP;
            end
            OP_CTRL: begin
              if (!in_value[7]) begin
                mode_nxt    = MODE_HBLANK;
                line_nxt    = 8'd0;
                disp_on_nxt = 1'b0;
              end else if (!disp_on_r) begin
                // restart at line 0
                cycle_nxt      = '0;
                scroll_pen_nxt = 3'd0;
                line_nxt       = 8'd0;
                chk            = line_check(compare_r, 8'd0, enables_r[3], 1'b0);
                match_nxt      = chk.match;
                lirq_nxt       = chk.irq;
                latched_nxt    = chk.latched;
                mode_nxt       = MODE_HBLANK;
                phase_nxt      = PH_XFER;
                plen_nxt       = OAM_LEN;
                disp_on_nxt    = 1'b1;
              end
            end
            OP_STAT: begin
              enables_nxt = in_value[6:3];
              lirq_nxt    = disp_on_r && (mode_r == MODE_HBLANK || mode_r == MODE_VBLANK);
            end
            default: begin
              if (compare_r != in_value) begin
                compare_nxt = in_value;
                if (phase_r != PH_HINC && phase_r != PH_VINC) begin
                  chk         = line_check(in_value, line_r, enables_r[3], latched_r);
                  match_nxt   = chk.match;
                  lirq_nxt    = chk.irq;
                  latched_nxt = chk.latched;
                end
              end
            end
          endcase
        end
      end

      S_LOOP: begin
        if (!boundary) begin
          state_nxt = S_DONE;
        end else begin
          cycle_nxt = cycle_rem;
          if (!disp_on_r) begin
            // display off: only mark frames
            line_nxt = 8'd0;
            plen_nxt = OFF_FRAME_LEN;
            done_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              PH_OAM: begin
                mode_nxt = MODE_OAM;
                if (enables_r[2] && !latched_r) begin
                  lirq_nxt = 1'b1;
                end
                chk = line_check(compare_r, line_r, enables_r[3],
                                 latched_r || enables_r[2]);
                match_nxt      = chk.match;
                lirq_nxt       = lirq_nxt || chk.irq;
                latched_nxt    = chk.latched;
                scroll_pen_nxt = sx_r[2] ? 3'd4 : 3'd0;
                phase_nxt      = PH_XFER;
                plen_nxt       = OAM_LEN;
              end
              PH_XFER: begin
                mode_nxt  = MODE_XFER;
                phase_nxt = PH_HBLANK;
                plen_nxt  = XFER_BASE_LEN + {14'd0, scroll_pen_r}
                          + {10'd0, sprite_penalty(sc_r)};
              end
              PH_HBLANK: begin
                mode_nxt = MODE_HBLANK;
                // H-blank interrupt, once per line
                if (enables_r[0] && !latched_r) begin
                  lirq_nxt    = 1'b1;
                  latched_nxt = 1'b1;
                end
                phase_nxt   = PH_HINC;
                plen_nxt    = HLINE_LEN - plen_r;
              end
              PH_HINC: begin
                line_nxt    = line_r + 8'd1;
                match_nxt   = 1'b0;
                latched_nxt = 1'b0;
                phase_nxt   = (line_nxt == VBLANK_LINE) ? PH_VBLANK : PH_OAM;
                plen_nxt    = INC_LEN;
              end
              PH_VBLANK: begin
                if (line_r == VBLANK_LINE) begin
                  mode_nxt = MODE_VBLANK;
                  virq_nxt = 1'b1;
                  if (enables_r[1]) begin
                    lirq_nxt = 1'b1;
                  end
                end
                chk = line_check(compare_r, line_r, enables_r[3], latched_r);
                match_nxt   = chk.match;
                lirq_nxt    = lirq_nxt || chk.irq;
                latched_nxt = chk.latched;
                phase_nxt   = PH_VINC;
                plen_nxt    = VLINE_LEN;
              end
              PH_VINC: begin
                line_nxt    = line_r + 8'd1;
                match_nxt   = 1'b0;
                latched_nxt = 1'b0;
                phase_nxt   = (line_nxt == LAST_LINE) ? PH_WRAP : PH_VBLANK;
                plen_nxt    = INC_LEN;
              end
              PH_WRAP: begin
                chk = line_check(compare_r, line_r, enables_r[3], latched_r);
                match_nxt   = chk.match;
                lirq_nxt    = lirq_r || chk.irq;
                latched_nxt = chk.latched;
                line_nxt    = 8'd0;
                phase_nxt   = PH_FRAME;
                plen_nxt    = VLINE_LEN;
              end
              default: begin
                mode_nxt    = MODE_HBLANK;
                latched_nxt = 1'b0;
                done_nxt    = 1'b1;
                phase_nxt   = PH_OAM;
                plen_nxt    = INC_LEN;
              end
            endcase
          end
        end
      end

      default: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {4'd0,
                          (!disp_on_r || mode_r == MODE_HBLANK || mode_r == MODE_VBLANK),
                          (!disp_on_r || mode_r != MODE_XFER),
                          done_r, virq_r, lirq_r,
                          enables_r, match_r, line_r, mode_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_OAM;
      line_r       <= 8'd0;
      cycle_r      <= '0;
      plen_r       <= '0;
      scroll_pen_r <= 3'd0;
      mode_r       <= MODE_HBLANK;
      match_r      <= 1'b0;
      enables_r    <= 4'd0;
      latched_r    <= 1'b0;
      disp_on_r    <= 1'b0;
      compare_r    <= 8'd0;
      lirq_r       <= 1'b0;
      virq_r       <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      line_r       <= line_nxt;
      cycle_r      <= cycle_nxt;
      plen_r       <= plen_nxt;
      scroll_pen_r <= scroll_pen_nxt;
      mode_r       <= mode_nxt;
      match_r      <= match_nxt;
      enables_r    <= enables_nxt;
      latched_r    <= latched_nxt;
      disp_on_r    <= disp_on_nxt;
      compare_r    <= compare_nxt;
      lirq_r       <= lirq_nxt;
      virq_r       <= virq_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    sc_r       <= sc_nxt;
    sx_r       <= sx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
